@@ rtl/ppmsp_pkg.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// ppmsp_pkg
// shared types and constants of the ppm stream parser
// -----------------------------------------------------------------------------

package ppmsp_pkg;

   // width of the internal image dimension counters
   localparam int DIM_BITS = 16;

   // result kinds
   localparam logic [1:0] KIND_PIXEL    = 2'd0;
   localparam logic [1:0] KIND_HEADER   = 2'd1;
   localparam logic [1:0] KIND_ERROR    = 2'd2;
   localparam logic [1:0] KIND_COMPLETE = 2'd3;

   // error codes
   localparam logic [3:0] ERR_BAD_FIRST   = 4'd0;
   localparam logic [3:0] ERR_BAD_TYPE    = 4'd1;
   localparam logic [3:0] ERR_NO_SEP      = 4'd2;
   localparam logic [3:0] ERR_EOF_COMMENT = 4'd3;
   localparam logic [3:0] ERR_BAD_WIDTH   = 4'd4;
   localparam logic [3:0] ERR_BAD_HEIGHT  = 4'd5;
   localparam logic [3:0] ERR_BAD_MAXVAL  = 4'd6;
   localparam logic [3:0] ERR_SAMPLE      = 4'd7;
   localparam logic [3:0] ERR_MISSING     = 4'd8;
   localparam logic [3:0] ERR_EXTRA       = 4'd9;
   localparam logic [3:0] ERR_EOF_HEADER  = 4'd10;

   // characters of the file format
   localparam logic [7:0] CHAR_P     = 8'h50;
   localparam logic [7:0] CHAR_3     = 8'h33;
   localparam logic [7:0] CHAR_6     = 8'h36;
   localparam logic [7:0] CHAR_HASH  = 8'h23;
   localparam logic [7:0] CHAR_LF    = 8'h0a;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] SAMPLE_MAX = 8'd255;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [7:0]  pixel_red;
      logic [7:0]  pixel_green;
      logic [7:0]  pixel_blue;
      logic [15:0] header_width;
      logic [15:0] header_height;
      logic [7:0]  header_max_value;
      logic        ascii_format;
      logic [3:0]  error_code;
      logic        last_pixel;
   } result_type;

endpackage

`default_nettype wire

@@ rtl/ppmsp_parser.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// ppmsp_parser
// byte-wise header and pixel parse state, held in registers
// -----------------------------------------------------------------------------

module ppmsp_parser (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   accept,
   input  wire logic [7:0]             data_byte,
   input  wire logic                   end_of_stream,
   output logic                        res_valid,
   output ppmsp_pkg::result_type       res
);

   localparam int DW    = ppmsp_pkg::DIM_BITS;
   localparam int ACC_W = DW + 1;
   localparam int MUL_W = ACC_W + 4;
   localparam logic [MUL_W-1:0] DIM_CAP = MUL_W'(1) << DW;
   localparam logic [MUL_W-1:0] TOK_CAP = MUL_W'(256);

   typedef enum logic [3:0] {
      PH_P, PH_TYPE, PH_SEP,
      PH_SKIP_W, PH_NUM_W, PH_SKIP_H, PH_NUM_H, PH_SKIP_M, PH_NUM_M,
      PH_RAW, PH_GAP, PH_TOK, PH_DONE, PH_HALT
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic              comment_ff, comment_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [2:0]        dcnt_ff, dcnt_in;
   logic [DW-1:0]     width_ff, width_in;
   logic [DW-1:0]     height_ff, height_in;
   logic              text_ff, text_in;
   logic [1:0]        comp_ff, comp_in;
   logic [7:0]        red_ff, red_in;
   logic [7:0]        green_ff, green_in;
   logic [DW-1:0]     col_ff, col_in;
   logic [DW-1:0]     row_ff, row_in;

   logic              is_ws, is_digit;
   logic [ACC_W-1:0]  acc_base;
   logic [MUL_W-1:0]  acc_mul, acc_sat;
   logic [7:0]        sample;
   logic [DW:0]       col_p1, row_p1;
   logic              last_px, put_req;
   logic [2:0]        dcnt_base;

   function automatic ppmsp_pkg::result_type err_result(input logic [3:0] code);
      ppmsp_pkg::result_type r;
      r = '0;
      r.result_kind = ppmsp_pkg::KIND_ERROR;
      r.error_code  = code;
      return r;
   endfunction

   assign is_ws    = (data_byte == 8'd32) || (data_byte >= 8'd9 && data_byte <= 8'd13);
   assign is_digit = (data_byte >= 8'd48) && (data_byte <= 8'd57);

   // token start clears the accumulator on the same byte
   assign acc_base  = (phase_ff == PH_GAP) ? '0 : acc_ff;
   assign dcnt_base = (phase_ff == PH_GAP) ? 3'd0 : dcnt_ff;
   assign acc_mul   = (MUL_W'(acc_base) << 3) + (MUL_W'(acc_base) << 1)
                    + MUL_W'(data_byte - ppmsp_pkg::CHAR_ZERO);
   always_comb begin
      if (phase_ff == PH_GAP || phase_ff == PH_TOK)
         acc_sat = (acc_mul > TOK_CAP) ? TOK_CAP : acc_mul;
      else
         acc_sat = (acc_mul > DIM_CAP) ? DIM_CAP : acc_mul;
   end

   assign sample  = (phase_ff == PH_RAW) ? data_byte : acc_ff[7:0];
   assign col_p1  = {1'b0, col_ff} + (DW+1)'(1);
   assign row_p1  = {1'b0, row_ff} + (DW+1)'(1);
   assign last_px = (col_p1 == {1'b0, width_ff}) && (row_p1 == {1'b0, height_ff});

   always_comb begin
      phase_in   = phase_ff;
      comment_in = comment_ff;
      acc_in     = acc_ff;
      dcnt_in    = dcnt_ff;
      width_in   = width_ff;
      height_in  = height_ff;
      text_in    = text_ff;
      comp_in    = comp_ff;
      red_in     = red_ff;
      green_in   = green_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      res_valid  = 1'b0;
      res        = '0;
      put_req    = 1'b0;

      if (accept && phase_ff != PH_HALT) begin
         if (end_of_stream) begin
            res_valid = 1'b1;
            phase_in  = PH_HALT;
            if (phase_ff inside {[PH_P:PH_NUM_M]}) begin
               res = err_result(comment_ff ? ppmsp_pkg::ERR_EOF_COMMENT
                                           : ppmsp_pkg::ERR_EOF_HEADER);
            end else if (phase_ff == PH_DONE) begin
               res.result_kind = ppmsp_pkg::KIND_COMPLETE;
            end else begin
               res = err_result(ppmsp_pkg::ERR_MISSING);
            end
         end else begin
            case (phase_ff)
               PH_P: begin
                  if (data_byte != ppmsp_pkg::CHAR_P) begin
                     res_valid = 1'b1;
                     res       = err_result(ppmsp_pkg::ERR_BAD_FIRST);
                     phase_in  = PH_HALT;
                  end else begin
                     phase_in = PH_TYPE;
                  end
               end
               PH_TYPE: begin
                  if (data_byte == ppmsp_pkg::CHAR_3) begin
                     text_in  = 1'b1;
                     phase_in = PH_SEP;
                  end else if (data_byte == ppmsp_pkg::CHAR_6) begin
                     text_in  = 1'b0;
                     phase_in = PH_SEP;
                  end else begin
                     res_valid = 1'b1;
                     res       = err_result(ppmsp_pkg::ERR_BAD_TYPE);
                     phase_in  = PH_HALT;
                  end
               end
               PH_SEP: begin
                  if (!is_ws) begin
                     res_valid = 1'b1;
                     res       = err_result(ppmsp_pkg::ERR_NO_SEP);
                     phase_in  = PH_HALT;
                  end else begin
                     phase_in = PH_SKIP_W;
                  end
               end
               PH_SKIP_W, PH_SKIP_H, PH_SKIP_M: begin
                  if (comment_ff) begin
                     if (data_byte == ppmsp_pkg::CHAR_LF) comment_in = 1'b0;
                  end else if (is_ws) begin
                     // skip
                  end else if (data_byte == ppmsp_pkg::CHAR_HASH) begin
                     comment_in = 1'b1;
                  end else if (!is_digit) begin
                     res_valid = 1'b1;
                     phase_in  = PH_HALT;
                     if (phase_ff == PH_SKIP_W)
                        res = err_result(ppmsp_pkg::ERR_BAD_WIDTH);
                     else if (phase_ff == PH_SKIP_H)
                        res = err_result(ppmsp_pkg::ERR_BAD_HEIGHT);
                     else
                        res = err_result(ppmsp_pkg::ERR_BAD_MAXVAL);
                  end else begin
                     acc_in = ACC_W'(data_byte - ppmsp_pkg::CHAR_ZERO);
                     if (phase_ff == PH_SKIP_W)      phase_in = PH_NUM_W;
                     else if (phase_ff == PH_SKIP_H) phase_in = PH_NUM_H;
                     else                            phase_in = PH_NUM_M;
                  end
               end
               PH_NUM_W, PH_NUM_H: begin
                  if (is_digit) begin
                     acc_in = ACC_W'(acc_sat);
                  end else if (acc_ff == '0 || acc_ff[DW]) begin
                     res_valid = 1'b1;
                     phase_in  = PH_HALT;
                     res = err_result((phase_ff == PH_NUM_W) ? ppmsp_pkg::ERR_BAD_WIDTH
                                                             : ppmsp_pkg::ERR_BAD_HEIGHT);
                  end else if (!is_ws) begin
                     res_valid = 1'b1;
                     res       = err_result(ppmsp_pkg::ERR_NO_SEP);
                     phase_in  = PH_HALT;
                  end else if (phase_ff == PH_NUM_W) begin
                     width_in = acc_ff[DW-1:0];
                     phase_in = PH_SKIP_H;
                  end else begin
                     height_in = acc_ff[DW-1:0];
                     phase_in  = PH_SKIP_M;
                  end
               end
               PH_NUM_M: begin
                  if (is_digit) begin
                     acc_in = ACC_W'(acc_sat);
                  end else if (acc_ff > ACC_W'(ppmsp_pkg::SAMPLE_MAX)) begin
                     res_valid = 1'b1;
                     res       = err_result(ppmsp_pkg::ERR_BAD_MAXVAL);
                     phase_in  = PH_HALT;
                  end else if (!is_ws) begin
                     res_valid = 1'b1;
                     res       = err_result(ppmsp_pkg::ERR_NO_SEP);
                     phase_in  = PH_HALT;
                  end else begin
                     res_valid            = 1'b1;
                     res.result_kind      = ppmsp_pkg::KIND_HEADER;
                     res.header_width     = 16'(width_ff);
                     res.header_height    = 16'(height_ff);
                     res.header_max_value = acc_ff[7:0];
                     res.ascii_format     = text_ff;
                     comp_in              = 2'd0;
                     col_in               = '0;
                     row_in               = '0;
                     phase_in             = text_ff ? PH_GAP : PH_RAW;
                  end
               end
               PH_RAW: begin
                  put_req = 1'b1;
               end
               PH_GAP, PH_TOK: begin
                  if (is_ws) begin
                     if (phase_ff == PH_TOK) begin
                        phase_in = PH_GAP;
                        if (dcnt_ff > 3'd3 || acc_ff > ACC_W'(ppmsp_pkg::SAMPLE_MAX)) begin
                           res_valid = 1'b1;
                           res       = err_result(ppmsp_pkg::ERR_SAMPLE);
                           phase_in  = PH_HALT;
                        end else begin
                           put_req = 1'b1;
                        end
                     end
                  end else begin
                     phase_in = PH_TOK;
                     dcnt_in  = (dcnt_base < 3'd7) ? dcnt_base + 3'd1 : dcnt_base;
                     acc_in   = is_digit ? ACC_W'(acc_sat) : ACC_W'(TOK_CAP);
                  end
               end
               PH_DONE: begin
                  if (!(text_ff && is_ws)) begin
                     res_valid = 1'b1;
                     res       = err_result(ppmsp_pkg::ERR_EXTRA);
                     phase_in  = PH_HALT;
                  end
               end
               default: begin
                  phase_in = PH_HALT;
               end
            endcase

            // gather samples into a pixel
            if (put_req) begin
               case (comp_ff)
                  2'd0: begin
                     red_in  = sample;
                     comp_in = 2'd1;
                  end
                  2'd1: begin
                     green_in = sample;
                     comp_in  = 2'd2;
                  end
                  default: begin
                     comp_in         = 2'd0;
                     res_valid       = 1'b1;
                     res.result_kind = ppmsp_pkg::KIND_PIXEL;
                     res.pixel_red   = red_ff;
                     res.pixel_green = green_ff;
                     res.pixel_blue  = sample;
                     res.last_pixel  = last_px;
                     if (col_p1 >= {1'b0, width_ff}) begin
                        col_in = '0;
                        row_in = row_p1[DW-1:0];
                     end else begin
                        col_in = col_p1[DW-1:0];
                     end
                     if (last_px) phase_in = PH_DONE;
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_P;
         comment_ff <= 1'b0;
         acc_ff     <= '0;
         dcnt_ff    <= '0;
         width_ff   <= '0;
         height_ff  <= '0;
         text_ff    <= 1'b0;
         comp_ff    <= '0;
         red_ff     <= '0;
         green_ff   <= '0;
         col_ff     <= '0;
         row_ff     <= '0;
      end else begin
         phase_ff   <= phase_in;
         comment_ff <= comment_in;
         acc_ff     <= acc_in;
         dcnt_ff    <= dcnt_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
         text_ff    <= text_in;
         comp_ff    <= comp_in;
         red_ff     <= red_in;
         green_ff   <= green_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/ppmsp_outbuf.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// ppmsp_outbuf
// result register with one skid entry
// -----------------------------------------------------------------------------

module ppmsp_outbuf (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire ppmsp_pkg::result_type  push_data,
   output logic                        full,
   output logic                        out_valid,
   input  wire logic                   out_stall,
   output ppmsp_pkg::result_type       out_data
);

   logic                  main_v_ff, skid_v_ff;
   ppmsp_pkg::result_type main_ff, skid_ff;
   logic                  take;

   assign take      = main_v_ff && !out_stall;
   assign full      = skid_v_ff;
   assign out_valid = main_v_ff;
   assign out_data  = main_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (take) begin
         if (skid_v_ff) begin
            main_ff   <= skid_ff;
            skid_v_ff <= 1'b0;
         end else begin
            main_v_ff <= push;
            main_ff   <= push_data;
         end
      end else if (!main_v_ff) begin
         main_v_ff <= push;
         main_ff   <= push_data;
      end else if (push) begin
         skid_v_ff <= 1'b1;
         skid_ff   <= push_data;
      end
   end

endmodule

`default_nettype wire

@@ rtl/ppm_stream_parser_top.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// ppm_stream_parser_top
// streaming reader for P3 and P6 portable pixmap files
// -----------------------------------------------------------------------------
// The block takes a PPM file one byte per request and returns a header
// result, one result per RGB pixel in raster order, then an image complete
// result, or an error result that halts it until reset. For each request
// the parse state updates with one multiply-by-ten add and the result is
// written into the output register, so a new request can be accepted on
// every cycle while req_stall is low. A one-entry skid buffer behind the
// output register lets a request be taken while a result waits; req_stall
// rises only when both are occupied. Results are registered and appear in
// the cycle after the request that causes them when the output register is
// free, and later while earlier results are held by rsp_stall. There is no
// clearing pass after reset.
// -----------------------------------------------------------------------------

module ppm_stream_parser_top (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_end_of_stream,
   // result channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_result_kind,
   output logic [7:0]       rsp_pixel_red,
   output logic [7:0]       rsp_pixel_green,
   output logic [7:0]       rsp_pixel_blue,
   output logic [15:0]      rsp_header_width,
   output logic [15:0]      rsp_header_height,
   output logic [7:0]       rsp_header_max_value,
   output logic             rsp_ascii_format,
   output logic [3:0]       rsp_error_code,
   output logic             rsp_last_pixel
);

   logic                  accept;     // request taken this cycle
   logic                  res_valid;  // request produces a result
   ppmsp_pkg::result_type res;
   ppmsp_pkg::result_type rsp;
   logic                  buf_full;

   // stall only while the skid entry is occupied
   assign req_stall = buf_full;
   assign accept    = req_valid && !req_stall;

   // parse state machine, one byte per cycle while requests are not stalled
   ppmsp_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .data_byte     (req_data_byte),
      .end_of_stream (req_end_of_stream),
      .res_valid     (res_valid),
      .res           (res)
   );

   // output register plus skid entry
   ppmsp_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .full      (buf_full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp)
   );

   // unpack the result onto the ports
   assign rsp_result_kind      = rsp.result_kind;
   assign rsp_pixel_red        = rsp.pixel_red;
   assign rsp_pixel_green      = rsp.pixel_green;
   assign rsp_pixel_blue       = rsp.pixel_blue;
   assign rsp_header_width     = rsp.header_width;
   assign rsp_header_height    = rsp.header_height;
   assign rsp_header_max_value = rsp.header_max_value;
   assign rsp_ascii_format     = rsp.ascii_format;
   assign rsp_error_code       = rsp.error_code;
   assign rsp_last_pixel       = rsp.last_pixel;

endmodule

`default_nettype wire

@@ rtl/ppmsp_checker.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// ppmsp_checker
// port-level checks of the ppm stream parser
// -----------------------------------------------------------------------------

module ppmsp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic [7:0]  req_data_byte,
   input wire logic        req_end_of_stream,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [1:0]  rsp_result_kind,
   input wire logic [7:0]  rsp_pixel_red,
   input wire logic [7:0]  rsp_pixel_green,
   input wire logic [7:0]  rsp_pixel_blue,
   input wire logic [15:0] rsp_header_width,
   input wire logic [15:0] rsp_header_height,
   input wire logic [7:0]  rsp_header_max_value,
   input wire logic        rsp_ascii_format,
   input wire logic [3:0]  rsp_error_code,
   input wire logic        rsp_last_pixel
);

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_kind)
         && $stable(rsp_pixel_blue) && $stable(rsp_error_code))
      else $error("stalled result changed");

   // an empty output stage never stalls requests
   a_no_stall_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with empty output");

   // error or completion is the final result
   a_halt_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && (rsp_result_kind == ppmsp_pkg::KIND_ERROR
         || rsp_result_kind == ppmsp_pkg::KIND_COMPLETE) |=> !rsp_valid)
      else $error("result after halt");

   // header fields are zero outside header results
   a_header_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind != ppmsp_pkg::KIND_HEADER
         |-> rsp_header_width == 16'd0 && rsp_header_max_value == 8'd0)
      else $error("header fields set on non-header result");

endmodule

bind ppm_stream_parser_top ppmsp_checker u_checker (.*);

`default_nettype wire
